[rtl/core/sensor_ring_calibrate_threshold_unit_assert.svh]
// Assertion macros shared by the checker of the sensor ring threshold unit.
`ifndef SENSOR_RING_CALIBRATE_THRESHOLD_UNIT_ASSERT_SVH
`define SENSOR_RING_CALIBRATE_THRESHOLD_UNIT_ASSERT_SVH

// Property checked on every rising clock edge, switched off while reset is high.
`define SRCT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
   else $error(msg);

// Property checked on every rising clock edge, reset cycles included.
`define SRCT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/core/srct_pkg.sv]
// Shared types, opcodes and the blend factor table of the sensor ring threshold unit.
package srct_pkg;

   localparam int OPCODE_W  = 2;
   localparam int CHANNEL_W = 4;
   localparam int READING_W = 10;
   localparam int COUNT_W   = 6;
   localparam int THRESH_W  = 10;
   localparam int BLEND_W   = 7;

   localparam logic [OPCODE_W-1:0] OP_CALIBRATE    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_DETECT       = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_LATCH  = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_THRESH = 2'd3;

   localparam logic [BLEND_W-1:0] BLEND_RESET = 7'd27;
   localparam int BLEND_MAX      = 100;
   localparam int BLEND_ENTRIES  = 1 << BLEND_W;
   localparam int FACTOR_TABLE_W = 32;

   typedef logic [FACTOR_TABLE_W-1:0] factor_table_type [BLEND_ENTRIES];

   // Control of the second stage, shared by both lanes and the merge stage.
   typedef struct packed {
      logic                fire;
      logic [OPCODE_W-1:0] op;
      logic                in_range;
      logic                first;
      logic                last;
   } stage_ctl_type;

   // What one lane reports for the item in its second stage.
   typedef struct packed {
      logic                active;
      logic                latched;
      logic [THRESH_W-1:0] threshold;
   } lane_status_type;

   // Entry b holds ceil(min(b, 100) * 2^shift / 100), so that
   // floor(span * b / 100) == (span * entry) >> shift for every span below 2^(shift-7).
   function automatic factor_table_type build_blend_table(input int shift);
      factor_table_type tbl;
      longint           num;
      int               b;
      for (int i = 0; i < BLEND_ENTRIES; i++) begin
         b      = (i > BLEND_MAX) ? BLEND_MAX : i;
         num    = (longint'(b) << shift) + longint'(BLEND_MAX - 1);
         tbl[i] = FACTOR_TABLE_W'(num / BLEND_MAX);
      end
      return tbl;
   endfunction

endpackage

[rtl/core/srct_lane.sv]
// One lane: minimum, maximum, threshold and latch store for half of the ring.
module srct_lane #(
   parameter int HALF        = 16,
   parameter int SAMPLE_BITS = 10,
   parameter int IDX_W       = 4,
   parameter int FACT_W      = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         take,
   input  logic [srct_pkg::OPCODE_W-1:0] take_op,
   input  logic                         take_in_range,
   input  logic [IDX_W-1:0]             take_index,
   input  logic [SAMPLE_BITS-1:0]       take_sample,
   input  logic [FACT_W-1:0]            factor,
   input  srct_pkg::stage_ctl_type      ctl,
   output srct_pkg::lane_status_type    status
);
   import srct_pkg::*;

   localparam int SHIFT  = SAMPLE_BITS + 7;
   localparam int PROD_W = SAMPLE_BITS + FACT_W;
   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

   logic [SAMPLE_BITS-1:0] min_ff [HALF];
   logic [SAMPLE_BITS-1:0] max_ff [HALF];
   logic [SAMPLE_BITS-1:0] thr_ff [HALF];
   logic [HALF-1:0]        latch_ff;

   logic [SAMPLE_BITS-1:0] cur_min, cur_max, min_in, max_in, span;
   logic [PROD_W-1:0]      prod_in;
   logic                   cal_take;

   logic [IDX_W-1:0]       idx_ff;
   logic [SAMPLE_BITS-1:0] sample_ff, low_ff;
   logic [PROD_W-1:0]      prod_ff;

   logic [SAMPLE_BITS-1:0] th_cur, th_cal, th_after;
   logic                   hit, is_detect;

   // First stage: the new minimum and maximum are stored at once, the span is scaled.
   assign cur_min  = min_ff[take_index];
   assign cur_max  = max_ff[take_index];
   assign min_in   = (take_sample < cur_min) ? take_sample : cur_min;
   assign max_in   = (take_sample > cur_max) ? take_sample : cur_max;
   assign span     = (max_in >= min_in) ? (max_in - min_in) : '0;
   assign prod_in  = PROD_W'(span) * PROD_W'(factor);
   assign cal_take = take && take_in_range && (take_op == OP_CALIBRATE);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HALF; i++) begin
            min_ff[i] <= FULL_SCALE;
            max_ff[i] <= '0;
         end
      end else if (cal_take) begin
         min_ff[take_index] <= min_in;
         max_ff[take_index] <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         idx_ff    <= take_index;
         sample_ff <= take_sample;
         low_ff    <= min_in;
         prod_ff   <= prod_in;
      end
   end

   // Second stage: threshold update, comparison and latches.
   assign th_cur    = thr_ff[idx_ff];
   assign th_cal    = low_ff + SAMPLE_BITS'(prod_ff >> SHIFT);
   assign hit       = sample_ff > th_cur;
   assign is_detect = ctl.in_range && (ctl.op == OP_DETECT);

   always_comb begin
      unique case (ctl.op)
         OP_CALIBRATE:    th_after = th_cal;
         OP_CLEAR_THRESH: th_after = '0;
         OP_DETECT,
         OP_CLEAR_LATCH:  th_after = th_cur;
      endcase
   end

   assign status.active    = is_detect && hit;
   assign status.latched   = is_detect && (latch_ff[idx_ff] || hit);
   assign status.threshold = ctl.in_range ? THRESH_W'(th_after) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HALF; i++) begin
            thr_ff[i] <= '0;
         end
         latch_ff <= '0;
      end else if (ctl.fire && ctl.in_range) begin
         unique case (ctl.op)
            OP_CALIBRATE: begin
               thr_ff[idx_ff] <= th_cal;
            end
            OP_DETECT: begin
               if (hit) begin
                  latch_ff[idx_ff] <= 1'b1;
               end
            end
            OP_CLEAR_LATCH: begin
               latch_ff <= '0;
            end
            OP_CLEAR_THRESH: begin
               for (int i = 0; i < HALF; i++) begin
                  thr_ff[i] <= '0;
               end
            end
         endcase
      end
   end

endmodule

[rtl/core/srct_merge.sv]
// Merge stage: frame counters from both lanes and the result register.
module srct_merge (
   input  logic                           clock,
   input  logic                           reset,
   input  srct_pkg::stage_ctl_type        ctl,
   input  srct_pkg::lane_status_type      status_low,
   input  srct_pkg::lane_status_type      status_high,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic                           rsp_active_low,
   output logic                           rsp_active_high,
   output logic [srct_pkg::COUNT_W-1:0]   rsp_active_count,
   output logic [srct_pkg::COUNT_W-1:0]   rsp_latched_count,
   output logic                           rsp_boundary_seen,
   output logic                           rsp_frame_done,
   output logic [srct_pkg::THRESH_W-1:0]  rsp_threshold_low,
   output logic [srct_pkg::THRESH_W-1:0]  rsp_threshold_high
);
   import srct_pkg::*;

   logic [COUNT_W-1:0]  active_ff, latched_ff, active_in, latched_in;
   logic [COUNT_W-1:0]  base_active, base_latched;
   logic [COUNT_W:0]    sum_active, sum_latched;
   logic                is_detect, frame_start, clear_latch;

   logic                out_valid_ff;
   logic                act_low_ff, act_high_ff, boundary_ff, done_ff;
   logic [COUNT_W-1:0]  out_active_ff, out_latched_ff;
   logic [THRESH_W-1:0] th_low_ff, th_high_ff;

   assign is_detect   = ctl.in_range && (ctl.op == OP_DETECT);
   assign frame_start = is_detect && ctl.first;
   assign clear_latch = ctl.in_range && (ctl.op == OP_CLEAR_LATCH);

   assign base_active  = frame_start ? '0 : active_ff;
   assign base_latched = (frame_start || clear_latch) ? '0 : latched_ff;

   // At most two sensors add per item, so the carry bit alone marks saturation.
   assign sum_active  = {1'b0, base_active} + (COUNT_W+1)'(status_low.active)
                      + (COUNT_W+1)'(status_high.active);
   assign sum_latched = {1'b0, base_latched} + (COUNT_W+1)'(status_low.latched)
                      + (COUNT_W+1)'(status_high.latched);
   assign active_in   = sum_active[COUNT_W] ? '1 : sum_active[COUNT_W-1:0];
   assign latched_in  = sum_latched[COUNT_W] ? '1 : sum_latched[COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         latched_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (ctl.fire) begin
            active_ff  <= active_in;
            latched_ff <= latched_in;
         end
         out_valid_ff <= ctl.fire || (out_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.fire) begin
         act_low_ff     <= status_low.active;
         act_high_ff    <= status_high.active;
         out_active_ff  <= active_in;
         out_latched_ff <= latched_in;
         boundary_ff    <= active_in != '0;
         done_ff        <= is_detect && ctl.last;
         th_low_ff      <= status_low.threshold;
         th_high_ff     <= status_high.threshold;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_active_low     = act_low_ff;
   assign rsp_active_high    = act_high_ff;
   assign rsp_active_count   = out_active_ff;
   assign rsp_latched_count  = out_latched_ff;
   assign rsp_boundary_seen  = boundary_ff;
   assign rsp_frame_done     = done_ff;
   assign rsp_threshold_low  = th_low_ff;
   assign rsp_threshold_high = th_high_ff;

endmodule

[rtl/core/sensor_ring_calibrate_threshold_unit.sv]
// Top level of the sensor ring calibration and threshold unit.
//
//   Channel   Direction  Handshake             Carries
//   req_      in         req_valid/req_ready   opcode, channel, two readings
//   rsp_      out        rsp_valid/rsp_ready   actives, frame counts, thresholds
//   csr_      in         csr_valid/csr_ready   blend percent
//
// The unit takes one item per clock while req_ready is high. A result moves from the
// stage registers into the result register when the second stage fires, and leaves it
// on a transfer with rsp_ready; the first stage is the span multiplier in each lane,
// the second the threshold update and the count merge into the result register.
// Reset leaves every store at its start value; no clearing pass.
// A stalled result holds the second stage, and input transfers pause only while
// both the second stage and the result register are full.
module sensor_ring_calibrate_threshold_unit #(
   parameter int SENSORS     = 32,
   parameter int SAMPLE_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [srct_pkg::OPCODE_W-1:0]   req_opcode,
   input  logic [srct_pkg::CHANNEL_W-1:0]  req_channel,
   input  logic [srct_pkg::READING_W-1:0]  req_reading_low,
   input  logic [srct_pkg::READING_W-1:0]  req_reading_high,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_active_low,
   output logic                            rsp_active_high,
   output logic [srct_pkg::COUNT_W-1:0]    rsp_active_count,
   output logic [srct_pkg::COUNT_W-1:0]    rsp_latched_count,
   output logic                            rsp_boundary_seen,
   output logic                            rsp_frame_done,
   output logic [srct_pkg::THRESH_W-1:0]   rsp_threshold_low,
   output logic [srct_pkg::THRESH_W-1:0]   rsp_threshold_high,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [srct_pkg::BLEND_W-1:0]    csr_blend_percent
);
   import srct_pkg::*;

   // Each lane owns half of the ring; the multiplexer channel indexes both.
   localparam int HALF   = SENSORS / 2;
   localparam int IDX_W  = (HALF > 1) ? $clog2(HALF) : 1;
   // The factor carries seven fraction bits beyond the sample width, which keeps
   // the scaled span exact for every blend from 0 to 100.
   localparam int FACT_W = SAMPLE_BITS + 8;
   localparam factor_table_type BLEND_TABLE = build_blend_table(SAMPLE_BITS + 7);

   logic [FACT_W-1:0] factor_ff;

   logic              accept, s1_move, fire;
   logic              take_in_range, take_first, take_last;
   logic [IDX_W-1:0]  take_index;
   logic              s1_valid_ff, s1_in_range_ff, s1_first_ff, s1_last_ff;
   logic [OPCODE_W-1:0] s1_op_ff;

   stage_ctl_type     ctl;
   lane_status_type   status_low, status_high;

   // The blend percent is kept only as its precomputed factor; blends above 100
   // share the factor of 100.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= BLEND_TABLE[BLEND_RESET][FACT_W-1:0];
      end else if (csr_valid && csr_ready) begin
         factor_ff <= BLEND_TABLE[csr_blend_percent][FACT_W-1:0];
      end
   end

   // Channels beyond the ring leave all state alone and report zero thresholds.
   assign take_in_range = 32'(req_channel) < 32'(HALF);
   assign take_first    = req_channel == '0;
   assign take_last     = 32'(req_channel) == 32'(HALF - 1);
   assign take_index    = IDX_W'(req_channel);

   // The second stage moves on whenever the result register is free or drained.
   assign s1_move   = !rsp_valid || rsp_ready;
   assign fire      = s1_valid_ff && s1_move;
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept || (s1_valid_ff && !s1_move);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_opcode;
         s1_in_range_ff <= take_in_range;
         s1_first_ff    <= take_first;
         s1_last_ff     <= take_last;
      end
   end

   assign ctl.fire     = fire;
   assign ctl.op       = s1_op_ff;
   assign ctl.in_range = s1_in_range_ff;
   assign ctl.first    = s1_first_ff;
   assign ctl.last     = s1_last_ff;

   srct_lane #(
      .HALF        (HALF),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .FACT_W      (FACT_W)
   ) u_lane_low (
      .clock         (clock),
      .reset         (reset),
      .take          (accept),
      .take_op       (req_opcode),
      .take_in_range (take_in_range),
      .take_index    (take_index),
      .take_sample   (SAMPLE_BITS'(req_reading_low)),
      .factor        (factor_ff),
      .ctl           (ctl),
      .status        (status_low)
   );

   srct_lane #(
      .HALF        (HALF),
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IDX_W),
      .FACT_W      (FACT_W)
   ) u_lane_high (
      .clock         (clock),
      .reset         (reset),
      .take          (accept),
      .take_op       (req_opcode),
      .take_in_range (take_in_range),
      .take_index    (take_index),
      .take_sample   (SAMPLE_BITS'(req_reading_high)),
      .factor        (factor_ff),
      .ctl           (ctl),
      .status        (status_high)
   );

   // The merge stage folds both lanes into the frame counts and the result.
   srct_merge u_merge (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .status_low         (status_low),
      .status_high        (status_high),
      .rsp_ready          (rsp_ready),
      .rsp_valid          (rsp_valid),
      .rsp_active_low     (rsp_active_low),
      .rsp_active_high    (rsp_active_high),
      .rsp_active_count   (rsp_active_count),
      .rsp_latched_count  (rsp_latched_count),
      .rsp_boundary_seen  (rsp_boundary_seen),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_threshold_low  (rsp_threshold_low),
      .rsp_threshold_high (rsp_threshold_high)
   );

endmodule

[rtl/core/srct_checker.sv]
// Port checker of the sensor ring threshold unit and its bind to the top level.
`include "sensor_ring_calibrate_threshold_unit_assert.svh"

module srct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic                            rsp_active_low,
   input logic                            rsp_active_high,
   input logic [srct_pkg::COUNT_W-1:0]    rsp_active_count,
   input logic [srct_pkg::COUNT_W-1:0]    rsp_latched_count,
   input logic                            rsp_boundary_seen,
   input logic [srct_pkg::THRESH_W-1:0]   rsp_threshold_low,
   input logic [srct_pkg::THRESH_W-1:0]   rsp_threshold_high
);
   import srct_pkg::*;

   // No result is pending right after reset.
   `SRCT_ASSERT_ALWAYS(a_reset_empties, reset |=> !rsp_valid, "result valid after reset")

   // The boundary flag follows the frame's active count.
   `SRCT_ASSERT(a_boundary_count, rsp_valid |-> (rsp_boundary_seen == (rsp_active_count != '0)), "boundary flag disagrees with active count")

   // An active sensor is always counted and always latched.
   `SRCT_ASSERT(a_active_counted, (rsp_valid && (rsp_active_low || rsp_active_high)) |-> ((rsp_active_count != '0) && (rsp_latched_count != '0)), "active sensor missing from counts")

   // A stalled result keeps its counts and thresholds.
   `SRCT_ASSERT(a_result_holds, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_active_count) && $stable(rsp_latched_count) && $stable(rsp_threshold_low) && $stable(rsp_threshold_high)), "stalled result changed")

endmodule

bind sensor_ring_calibrate_threshold_unit srct_checker u_checker (.*);
